/* rtl/stq_pkg.sv */
package stq_pkg;

  localparam int TimeW  = 48;
  localparam int ActW   = 8;
  localparam int OwnW   = 16;
  localparam int RemW   = 49;
  localparam int MaxOut = 16;
  localparam int NW     = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_EXPIRE = 2'd3
  } status_t;

  typedef struct packed {
    logic [TimeW-1:0] dl;
    logic [ActW-1:0]  act;
    logic [OwnW-1:0]  own;
  } entry_t;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_A_RD  = 15'b000000000000010,
    S_A_CHK = 15'b000000000000100,
    S_D_RD  = 15'b000000000001000,
    S_D_CHK = 15'b000000000010000,
    S_E_RD  = 15'b000000000100000,
    S_E_CHK = 15'b000000001000000,
    S_E_GO  = 15'b000000010000000,
    S_X_RD  = 15'b000000100000000,
    S_X_CHK = 15'b000001000000000,
    S_WAIT  = 15'b000010000000000,
    S_H_RD  = 15'b000100000000000,
    S_H_CHK = 15'b001000000000000,
    S_F_RD  = 15'b010000000000000,
    S_F_GO  = 15'b100000000000000
  } state_t;

endpackage

/* rtl/sorted_timer_queue_unit.sv */
// Channel | Direction | Signals                                   | Contents
// s       | in        | s_tvalid s_tready s_tdata s_tuser         | one operation, current time
// m       | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | one or more results
//
// One transaction is taken at a time; s_tready is high only while the unit is idle.
// Add reads each entry with a later deadline and moves it up one place, then writes the
// new entry in its place; a full add only reads the head. Delete reads every stored
// entry and moves those after the first match down one place. Expire scans the due
// prefix, emits each due entry as a result and then moves the remaining entries down.
// Reset (rst, synchronous) empties the queue at once; memory contents are never cleared.
// A stalled m_tready holds the result register and the whole sequence behind it.
module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_ms [47:0], time_value [95:48], callback_tag [103:96], owner_tag [119:104]
  input  logic [119:0] s_tdata,
  // op [1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // deadline [47:0], callback_tag_res [55:48], owner_tag_res [71:56],
  // remaining_ms [120:72], zero pad [127:121]
  output logic [127:0] m_tdata,
  // status [1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t state;

  // Latched operation.
  op_t              op_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] tv_q;
  logic [ActW-1:0]  act_q;
  logic [OwnW-1:0]  own_q;
  logic [TimeW-1:0] dl_new;

  // Walk state: i indexes the entries, n counts due entries on expire.
  logic [CW-1:0]    count;
  logic [CW-1:0]    i;
  logic [NW-1:0]    n;
  logic             found;
  status_t          st_q;
  logic [RemW-1:0]  rem;

  // Result register.
  status_t          o_status;
  logic [TimeW-1:0] o_dl;
  logic [ActW-1:0]  o_act;
  logic [OwnW-1:0]  o_own;
  logic [RemW-1:0]  o_rem;
  logic             o_last;

  // Memory port.
  logic          wen;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic          ren;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  logic [TimeW:0]  sum;
  logic [CW-1:0]   i_dec;
  logic [CW-1:0]   i_sub_n;
  entry_t          new_entry;

  assign sum       = {1'b0, s_tdata[47:0]} + {1'b0, s_tdata[95:48]};
  assign i_dec     = i - CW'(1);
  assign i_sub_n   = i - CW'(n);
  assign new_entry = '{dl: dl_new, act: act_q, own: own_q};

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_WAIT);
  assign m_tuser  = o_status;
  assign m_tlast  = o_last;
  assign m_tdata  = {7'd0, o_rem, o_own, o_act, o_dl};

  stq_mem #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_mem (
    .clk  (clk),
    .wen  (wen),
    .waddr(waddr),
    .wdata(wdata),
    .ren  (ren),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Memory control follows the same conditions as the sequencer below.
  always_comb begin
    wen   = 1'b0;
    waddr = i[IW-1:0];
    wdata = rdata;
    ren   = 1'b0;
    raddr = i[IW-1:0];
    unique case (state)
      S_A_RD: begin
        if (i == '0) begin
          wen   = 1'b1;
          waddr = '0;
          wdata = new_entry;
        end else begin
          ren   = 1'b1;
          raddr = i_dec[IW-1:0];
        end
      end
      S_A_CHK: begin
        // Either move the read entry up one place or drop the new one in.
        wen = 1'b1;
        if (rdata.dl <= dl_new) begin
          wdata = new_entry;
        end
      end
      S_D_RD, S_E_RD, S_H_RD: begin
        ren = (i != count);
      end
      S_D_CHK: begin
        wen   = found;
        waddr = i_dec[IW-1:0];
      end
      S_X_RD: begin
        ren = 1'b1;
      end
      S_H_CHK: begin
        wen   = 1'b1;
        waddr = i_sub_n[IW-1:0];
      end
      S_F_RD: begin
        ren   = 1'b1;
        raddr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q  <= op_t'(s_tuser);
            now_q <= s_tdata[47:0];
            tv_q  <= s_tdata[95:48];
            act_q <= s_tdata[103:96];
            own_q <= s_tdata[119:104];
            i     <= '0;
            n     <= '0;
            found <= 1'b0;
            unique case (op_t'(s_tuser))
              OP_ADD: begin
                if (count == CW'(CAPACITY)) begin
                  st_q   <= ST_FULL;
                  dl_new <= '0;
                  state  <= S_F_RD;
                end else begin
                  st_q   <= ST_OK;
                  dl_new <= sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
                  i      <= count;
                  state  <= S_A_RD;
                end
              end
              OP_DELETE: begin
                dl_new <= '0;
                state  <= S_D_RD;
              end
              OP_EXPIRE: state <= S_E_RD;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_A_RD: begin
          if (i == '0) begin
            count <= count + CW'(1);
            state <= S_F_RD;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (rdata.dl > dl_new) begin
            i     <= i_dec;
            state <= S_A_RD;
          end else begin
            count <= count + CW'(1);
            state <= S_F_RD;
          end
        end
        S_D_RD: begin
          if (i == count) begin
            if (found) begin
              count <= count - CW'(1);
            end
            st_q  <= found ? ST_OK : ST_NOT_FOUND;
            state <= S_F_RD;
          end else begin
            state <= S_D_CHK;
          end
        end
        S_D_CHK: begin
          // Entries after the first match shift down one place.
          if (!found && rdata.dl == tv_q && rdata.own == own_q) begin
            found <= 1'b1;
          end
          i     <= i + CW'(1);
          state <= S_D_RD;
        end
        S_E_RD: begin
          if (i == count) begin
            rem   <= '0;
            state <= S_E_GO;
          end else begin
            state <= S_E_CHK;
          end
        end
        S_E_CHK: begin
          // Due entries form a prefix; the first one left sets the remaining time.
          if (rdata.dl <= now_q && n != NW'(MaxOut)) begin
            n     <= n + NW'(1);
            i     <= i + CW'(1);
            state <= S_E_RD;
          end else begin
            rem   <= {1'b0, rdata.dl} - {1'b0, now_q};
            state <= S_E_GO;
          end
        end
        S_E_GO: begin
          if (n == '0) begin
            o_status <= ST_NO_EXPIRE;
            o_dl     <= '0;
            o_act    <= '0;
            o_own    <= '0;
            o_rem    <= rem;
            o_last   <= 1'b1;
            state    <= S_WAIT;
          end else begin
            i     <= '0;
            state <= S_X_RD;
          end
        end
        S_X_RD: state <= S_X_CHK;
        S_X_CHK: begin
          o_status <= ST_OK;
          o_dl     <= rdata.dl;
          o_act    <= rdata.act;
          o_own    <= rdata.own;
          o_rem    <= rem;
          o_last   <= (i + CW'(1) == CW'(n));
          state    <= S_WAIT;
        end
        S_WAIT: begin
          if (m_tready) begin
            if (op_q == OP_EXPIRE && n != '0) begin
              if (o_last) begin
                i     <= CW'(n);
                state <= S_H_RD;
              end else begin
                i     <= i + CW'(1);
                state <= S_X_RD;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_H_RD: begin
          if (i == count) begin
            count <= count - CW'(n);
            state <= S_IDLE;
          end else begin
            state <= S_H_CHK;
          end
        end
        S_H_CHK: begin
          i     <= i + CW'(1);
          state <= S_H_RD;
        end
        S_F_RD: begin
          // Read the head; the result is built once the data returns.
          state <= S_F_GO;
        end
        S_F_GO: begin
          // Single result of add or delete, with the head's remaining time.
          o_status <= st_q;
          o_dl     <= dl_new;
          o_act    <= '0;
          o_own    <= '0;
          o_rem    <= (count != '0) ? ({1'b0, rdata.dl} - {1'b0, now_q}) : '0;
          o_last   <= 1'b1;
          state    <= S_WAIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/stq_mem.sv */
module stq_mem
  import stq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sim/tb_sorted_timer_queue_unit.sv */
module tb_sorted_timer_queue_unit;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = 16;
  localparam int WatchdogLimit = 20000;
  localparam logic [TimeW-1:0] TimeTop = {TimeW{1'b1}};

  // One operation as offered on the input stream.
  typedef struct {
    op_t              op;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] time_value;
    logic [ActW-1:0]  cb_tag;
    logic [OwnW-1:0]  own_tag;
  } timer_op_t;

  // One result as seen on the output stream.
  typedef struct {
    status_t          status;
    logic [TimeW-1:0] deadline;
    logic [ActW-1:0]  cb_tag;
    logic [OwnW-1:0]  own_tag;
    logic [RemW-1:0]  remaining;
    logic             last;
  } timer_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  always #10 clk = ~clk;

  sorted_timer_queue_unit #(.CAPACITY(Capacity)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // The predictor keeps its own sorted copy of the timer table.
  entry_t           timer_table[$];
  timer_op_t        pending_ops[$];
  timer_res_t       expected_results[$];
  int               error_count = 0;
  bit               stimulus_done = 1'b0;
  bit               hold_receiver = 1'b0;
  bit               drain_request = 1'b0;

  // Applies one operation to the predicted table and queues the results it causes.
  task automatic predict_timer_op(input timer_op_t t);
    timer_res_t res[$];
    timer_res_t r;
    entry_t e;
    logic [TimeW:0] sum;
    logic [RemW-1:0] rem;
    int pos;
    bit found;
    r = '{ST_OK, '0, '0, '0, '0, 1'b0};
    case (t.op)
      OP_ADD: begin
        if (timer_table.size() >= Capacity) begin
          r.status = ST_FULL;
          res.push_back(r);
        end else begin
          sum = {1'b0, t.now_ms} + {1'b0, t.time_value};
          e.dl = sum[TimeW] ? TimeTop : sum[TimeW-1:0];
          e.act = t.cb_tag;
          e.own = t.own_tag;
          pos = timer_table.size();
          for (int i = 0; i < timer_table.size(); i++) begin
            if (timer_table[i].dl > e.dl) begin
              pos = i;
              break;
            end
          end
          timer_table.insert(pos, e);
          r.deadline = e.dl;
          res.push_back(r);
        end
      end
      OP_DELETE: begin
        found = 1'b0;
        for (int i = 0; i < timer_table.size(); i++) begin
          if (timer_table[i].dl == t.time_value && timer_table[i].own == t.own_tag) begin
            timer_table.delete(i);
            found = 1'b1;
            break;
          end
        end
        r.status = found ? ST_OK : ST_NOT_FOUND;
        res.push_back(r);
      end
      OP_EXPIRE: begin
        while (res.size() < MaxOut && timer_table.size() > 0 &&
               timer_table[0].dl <= t.now_ms) begin
          r.deadline = timer_table[0].dl;
          r.cb_tag = timer_table[0].act;
          r.own_tag = timer_table[0].own;
          res.push_back(r);
          void'(timer_table.pop_front());
        end
        if (res.size() == 0) begin
          r.status = ST_NO_EXPIRE;
          res.push_back(r);
        end
      end
      default: return;  // the unused selector changes nothing
    endcase
    rem = timer_table.size() > 0 ?
          {1'b0, timer_table[0].dl} - {1'b0, t.now_ms} : '0;
    foreach (res[k]) begin
      res[k].remaining = rem;
      res[k].last = (k == res.size() - 1);
      expected_results.push_back(res[k]);
    end
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    logic [TimeW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = TimeW'($urandom_range(0, 50));
      1: v = TimeTop - TimeW'($urandom_range(0, 50));
      default: v = TimeW'({$urandom(), $urandom()});
    endcase
    return v;
  endfunction

  function automatic timer_op_t make_op(op_t op, logic [TimeW-1:0] now_ms,
                                        logic [TimeW-1:0] tv, logic [ActW-1:0] cb,
                                        logic [OwnW-1:0] own);
    timer_op_t t;
    t.op = op;
    t.now_ms = now_ms;
    t.time_value = tv;
    t.cb_tag = cb;
    t.own_tag = own;
    return t;
  endfunction

  // Stimulus. A list of recently offered adds lets most deletes name such a timer,
  // and a slowly advancing clock lets expires catch several timers at once.
  initial begin : stimulus
    logic [TimeW-1:0] clock_ms;
    logic [TimeW-1:0] dls[$];
    logic [OwnW-1:0]  owners[$];
    timer_op_t t;
    int pick;
    int burst;
    // Directed part: extremes, saturation, ties, full store, empty expire, unused op.
    pending_ops.push_back(make_op(OP_EXPIRE, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_DELETE, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_ADD, TimeTop, TimeTop, 8'hFF, 16'hFFFF));
    pending_ops.push_back(make_op(OP_ADD, '0, 48'd5, 8'hA5, 16'h1234));
    pending_ops.push_back(make_op(OP_ADD, '0, 48'd5, 8'h5A, 16'h1234));
    pending_ops.push_back(make_op(OP_NONE, TimeTop, TimeTop, 8'hFF, 16'hFFFF));
    pending_ops.push_back(make_op(OP_DELETE, '0, 48'd5, '0, 16'h1234));
    pending_ops.push_back(make_op(OP_DELETE, '0, 48'd5, '0, 16'h4321));
    for (int i = 0; i < 15; i++)
      pending_ops.push_back(make_op(OP_ADD, 48'd10, TimeW'(i), ActW'(i), OwnW'(i)));
    pending_ops.push_back(make_op(OP_ADD, 48'd10, 48'd1, 8'h11, 16'h2222));
    pending_ops.push_back(make_op(OP_EXPIRE, 48'd3, '0, '0, '0));
    pending_ops.push_back(make_op(OP_EXPIRE, TimeTop, '0, '0, '0));
    pending_ops.push_back(make_op(OP_EXPIRE, TimeTop, '0, '0, '0));
    // Random part.
    clock_ms = 48'd1000;
    for (int n = 0; n < 400; n++) begin
      if ($urandom_range(0, 9) == 0) clock_ms = rand_time();
      else clock_ms = clock_ms + TimeW'($urandom_range(0, 40));
      pick = int'($urandom_range(0, 99));
      if (pick < 50) begin
        t = make_op(OP_ADD, clock_ms, $urandom_range(0, 3) == 0 ? rand_time()
                    : TimeW'($urandom_range(0, 200)), ActW'($urandom()),
                    OwnW'($urandom_range(0, 7)));
        if ($urandom_range(0, 7) == 0) t.own_tag = OwnW'($urandom());
        dls.push_back(t.now_ms + t.time_value > t.now_ms || t.time_value == 0 ?
                      t.now_ms + t.time_value : TimeTop);
        owners.push_back(t.own_tag);
      end else if (pick < 72) begin
        t = make_op(OP_DELETE, clock_ms, rand_time(), ActW'($urandom()),
                    OwnW'($urandom()));
        if (dls.size() > 0 && $urandom_range(0, 3) != 0) begin
          burst = int'($urandom_range(0, dls.size() - 1));
          t.time_value = dls[burst];
          t.own_tag = owners[burst];
          if ($urandom_range(0, 5) == 0) t.own_tag ^= 16'h1;
        end
      end else if (pick < 97) begin
        t = make_op(OP_EXPIRE, clock_ms, rand_time(), ActW'($urandom()),
                    OwnW'($urandom()));
      end else begin
        t = make_op(OP_NONE, clock_ms, rand_time(), ActW'($urandom()),
                    OwnW'($urandom()));
      end
      if (dls.size() > 40) begin
        void'(dls.pop_front());
        void'(owners.pop_front());
      end
      pending_ops.push_back(t);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: bursts of transactions with random gaps. Midway it drains the
  // unit once, and one long receiver hold-off lets the input back up.
  int burst_left = 0;
  int gap_left = 0;
  int sent_count = 0;
  timer_op_t cur_op;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_timer_op(cur_op);
        sent_count <= sent_count + 1;
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered transaction
      end else if (sent_count + int'(s_tvalid && s_tready) == 200 && !drain_request) begin
        drain_request <= 1'b1;
        s_tvalid <= 1'b0;
      end else if (drain_request && sent_count == 200 && expected_results.size() != 0) begin
        s_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_op.op;
        s_tdata <= {cur_op.own_tag, cur_op.cb_tag, cur_op.time_value, cur_op.now_ms};
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= int'($urandom_range(0, 12));
          gap_left <= $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 25)) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long stall of the receiver, counted in its own process.
  initial begin
    wait (sent_count >= 100);
    hold_receiver = 1'b1;
    repeat (400) @(posedge clk);
    hold_receiver = 1'b0;
  end

  // Receiver pattern: phases of full speed, light and heavy stalling.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= int'($urandom_range(0, 2));
    if (hold_receiver) m_tready <= 1'b0;
    else case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 3) != 0;
      default: m_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // Monitor: compares every result transaction with the oldest expectation.
  timer_res_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: status %0d deadline %0h", m_tuser,
               m_tdata[47:0]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[47:0] !== want.deadline) begin
          $error("deadline: expected %0h, actual %0h", want.deadline, m_tdata[47:0]);
          error_count++;
        end
        if (m_tdata[55:48] !== want.cb_tag) begin
          $error("callback_tag_res: expected %0h, actual %0h", want.cb_tag,
                 m_tdata[55:48]);
          error_count++;
        end
        if (m_tdata[71:56] !== want.own_tag) begin
          $error("owner_tag_res: expected %0h, actual %0h", want.own_tag,
                 m_tdata[71:56]);
          error_count++;
        end
        if (m_tdata[120:72] !== want.remaining) begin
          $error("remaining_ms: expected %0h, actual %0h", want.remaining,
                 m_tdata[120:72]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any transaction on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // End of run: all stimulus taken, nothing outstanding, then a short settle.
  initial begin
    wait (stimulus_done);
    wait (pending_ops.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/stq_pkg.sv
rtl/stq_mem.sv
rtl/sorted_timer_queue_unit.sv
sim/tb_sorted_timer_queue_unit.sv
